FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ppp_pkg.sv
// types and constants for the pinhole point projection
package ppp_pkg;

    // restoring divider: one quotient bit per stage
    localparam int QUOT_W  = 21;
    localparam int REM_W   = 50;
    localparam int DEN_W   = 32;
    localparam int CMP_W   = 54;

    // near plane limit on raw Q12.16 depth
    localparam logic signed [27:0] NEAR_LIMIT = 28'sd65;

    // saturation bounds
    localparam logic signed [27:0] DEPTH_MAX = 28'sd8388607;
    localparam logic signed [27:0] DEPTH_MIN = -28'sd8388608;
    localparam logic signed [23:0] PIX_MAX   = 24'sd524287;
    localparam logic signed [23:0] PIX_MIN   = -24'sd524288;

    // register map, one register per 8-byte slot
    typedef enum logic [2:0] {
        REG_ROT_X    = 3'd0,
        REG_ROT_Y    = 3'd1,
        REG_ROT_Z    = 3'd2,
        REG_TRANS_X  = 3'd3,
        REG_TRANS_Y  = 3'd4,
        REG_TRANS_Z  = 3'd5,
        REG_FOCAL    = 3'd6,
        REG_CENTRE   = 3'd7
    } reg_addr_t;

    // one item inside the divider stages
    typedef struct packed {
        logic [REM_W-1:0]  rem_u;
        logic [REM_W-1:0]  rem_v;
        logic [QUOT_W-1:0] q_u;
        logic [QUOT_W-1:0] q_v;
        logic [DEN_W-1:0]  den;
        logic              neg_u;
        logic              neg_v;
        logic              sat_u;
        logic              sat_v;
        logic              near;
        logic signed [23:0] dep;
    } div_t;

endpackage

FILE: rtl/core/pinhole_point_projection.sv
// pinhole point projection: world point to camera depth and pixel coordinates
// an accepted item moves through the input, product, row-sum, focal, divider and output registers in turn
// throughput: one item per cycle while in_stall is low; the 21-stage restoring divider sets the depth
// an output skid register lets one more item enter while a result is stalled
// reset clears all valid bits and loads the identity rotation, zero elsewhere
module pinhole_point_projection (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [23:0]   point_x,
    input  logic signed [23:0]   point_y,
    input  logic signed [23:0]   point_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [23:0]   depth,
    output logic signed [19:0]   pix_u,
    output logic signed [19:0]   pix_v,
    output logic                 near_plane
);
    import ppp_pkg::*;

    localparam int STAGES = QUOT_W + 5;

    // configuration registers
    logic [47:0] rot_x_reg, rot_y_reg, rot_z_reg;
    logic [23:0] trans_x_reg, trans_y_reg, trans_z_reg;
    logic [19:0] focal_reg;
    logic [31:0] centre_reg;
    logic        wr_en;
    reg_addr_t   addr;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign addr   = reg_addr_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg   <= 48'h0000_0000_4000;
            rot_y_reg   <= 48'h0000_4000_0000;
            rot_z_reg   <= 48'h4000_0000_0000;
            trans_x_reg <= '0;
            trans_y_reg <= '0;
            trans_z_reg <= '0;
            focal_reg   <= '0;
            centre_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (addr)
                REG_ROT_X:   rot_x_reg   <= pwdata[47:0];
                REG_ROT_Y:   rot_y_reg   <= pwdata[47:0];
                REG_ROT_Z:   rot_z_reg   <= pwdata[47:0];
                REG_TRANS_X: trans_x_reg <= pwdata[23:0];
                REG_TRANS_Y: trans_y_reg <= pwdata[23:0];
                REG_TRANS_Z: trans_z_reg <= pwdata[23:0];
                REG_FOCAL:   focal_reg   <= pwdata[19:0];
                REG_CENTRE:  centre_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (addr)
            REG_ROT_X:   prdata = {16'd0, rot_x_reg};
            REG_ROT_Y:   prdata = {16'd0, rot_y_reg};
            REG_ROT_Z:   prdata = {16'd0, rot_z_reg};
            REG_TRANS_X: prdata = {40'd0, trans_x_reg};
            REG_TRANS_Y: prdata = {40'd0, trans_y_reg};
            REG_TRANS_Z: prdata = {40'd0, trans_z_reg};
            REG_FOCAL:   prdata = {44'd0, focal_reg};
            REG_CENTRE:  prdata = {32'd0, centre_reg};
            default:     prdata = '0;
        endcase
    end

    // pipeline enable and valid bits
    logic                 en;
    logic [STAGES-1:0]    vld_reg;
    logic                 skid_valid_reg;
    logic                 out_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    // stage 0: input register
    logic signed [23:0] p_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= point_x;
            p_reg[1] <= point_y;
            p_reg[2] <= point_z;
        end
    end

    // stage 1: nine coefficient products
    logic signed [39:0] prod_next [9];
    logic signed [39:0] prod_reg  [9];
    logic [47:0]        rows [3];

    assign rows[0] = rot_x_reg;
    assign rows[1] = rot_y_reg;
    assign rows[2] = rot_z_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                prod_next[r*3+c] = 40'(signed'(rows[r][c*16 +: 16]) * p_reg[c]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    // stage 2: row sums plus translation, rounded to Q12.16
    logic signed [41:0] acc [3];
    logic signed [23:0] trans [3];
    logic signed [27:0] cam_reg [3];

    assign trans[0] = trans_x_reg;
    assign trans[1] = trans_y_reg;
    assign trans[2] = trans_z_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            acc[r] = 42'(prod_reg[r*3]) + 42'(prod_reg[r*3+1]) + 42'(prod_reg[r*3+2])
                   + (42'(trans[r]) <<< 14) + 42'sd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int r = 0; r < 3; r++)
                cam_reg[r] <= acc[r][41:14];
    end

    // stage 3: focal scaling, depth saturation and near test
    logic signed [48:0] num_u_reg, num_v_reg;
    logic signed [27:0] tz_reg;
    logic signed [23:0] dep_reg;
    logic               near_reg;
    logic signed [20:0] focal_s;
    logic signed [27:0] dep_sat;

    assign focal_s = signed'({1'b0, focal_reg});
    assign dep_sat = (cam_reg[2] > DEPTH_MAX) ? DEPTH_MAX :
                     (cam_reg[2] < DEPTH_MIN) ? DEPTH_MIN : cam_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_u_reg <= focal_s * cam_reg[0];
            num_v_reg <= focal_s * cam_reg[1];
            tz_reg    <= cam_reg[2];
            dep_reg   <= dep_sat[23:0];
            near_reg  <= (cam_reg[2] >= -NEAR_LIMIT) && (cam_reg[2] <= NEAR_LIMIT);
        end
    end

    // stage 4: magnitudes, half-divisor rounding and quotient overflow test
    logic [27:0]      abs_tz;
    logic [48:0]      abs_u, abs_v;
    logic [DEN_W-1:0] den4;
    logic [REM_W-1:0] n_u, n_v;
    logic [CMP_W-1:0] den_top;
    div_t             div_reg  [QUOT_W+1];
    div_t             div_next [QUOT_W+1];

    always_comb
    begin
        abs_tz  = tz_reg[27] ? 28'(-tz_reg) : 28'(tz_reg);
        abs_u   = num_u_reg[48] ? 49'(-num_u_reg) : 49'(num_u_reg);
        abs_v   = num_v_reg[48] ? 49'(-num_v_reg) : 49'(num_v_reg);
        den4    = {abs_tz, 4'd0};
        n_u     = 50'(abs_u) + 50'({abs_tz, 3'd0});
        n_v     = 50'(abs_v) + 50'({abs_tz, 3'd0});
        den_top = CMP_W'(den4) << QUOT_W;

        div_next[0].rem_u = n_u;
        div_next[0].rem_v = n_v;
        div_next[0].q_u   = '0;
        div_next[0].q_v   = '0;
        div_next[0].den   = den4;
        div_next[0].neg_u = num_u_reg[48] ^ tz_reg[27];
        div_next[0].neg_v = num_v_reg[48] ^ tz_reg[27];
        div_next[0].sat_u = CMP_W'(n_u) >= den_top;
        div_next[0].sat_v = CMP_W'(n_v) >= den_top;
        div_next[0].near  = near_reg;
        div_next[0].dep   = dep_reg;
    end

    // divider stages, one quotient bit each, msb first
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        localparam int BIT = QUOT_W - 1 - k;
        logic [CMP_W-1:0] trial;

        always_comb
        begin
            trial         = CMP_W'(div_reg[k].den) << BIT;
            div_next[k+1] = div_reg[k];
            if (CMP_W'(div_reg[k].rem_u) >= trial)
            begin
                div_next[k+1].rem_u    = REM_W'(CMP_W'(div_reg[k].rem_u) - trial);
                div_next[k+1].q_u[BIT] = 1'b1;
            end
            if (CMP_W'(div_reg[k].rem_v) >= trial)
            begin
                div_next[k+1].rem_v    = REM_W'(CMP_W'(div_reg[k].rem_v) - trial);
                div_next[k+1].q_v[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            for (int k = 0; k <= QUOT_W; k++)
                div_reg[k] <= div_next[k];
    end

    // final: sign, centre offset, saturation, near blanking
    logic signed [23:0] qs_u, qs_v, sum_u, sum_v;
    logic signed [19:0] res_u, res_v;
    div_t               fin;

    assign fin = div_reg[QUOT_W];

    always_comb
    begin
        qs_u  = fin.sat_u ? 24'sh200000 : signed'({3'd0, fin.q_u});
        qs_v  = fin.sat_v ? 24'sh200000 : signed'({3'd0, fin.q_v});
        qs_u  = fin.neg_u ? -qs_u : qs_u;
        qs_v  = fin.neg_v ? -qs_v : qs_v;
        sum_u = qs_u + signed'({8'd0, centre_reg[15:0]});
        sum_v = qs_v + signed'({8'd0, centre_reg[31:16]});
        res_u = (sum_u > PIX_MAX) ? PIX_MAX[19:0] :
                (sum_u < PIX_MIN) ? PIX_MIN[19:0] : sum_u[19:0];
        res_v = (sum_v > PIX_MAX) ? PIX_MAX[19:0] :
                (sum_v < PIX_MIN) ? PIX_MIN[19:0] : sum_v[19:0];
        if (fin.near)
        begin
            res_u = '0;
            res_v = '0;
        end
    end

    // output register with skid stage
    logic               vin;
    logic signed [23:0] out_dep_reg, skid_dep_reg;
    logic signed [19:0] out_u_reg, out_v_reg, skid_u_reg, skid_v_reg;
    logic               out_near_reg, skid_near_reg;
    logic               hold;

    assign vin  = vld_reg[STAGES-1] && en;
    assign hold = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (hold)
        begin
            if (vin)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            if (vin)
            begin
                skid_dep_reg  <= fin.dep;
                skid_u_reg    <= res_u;
                skid_v_reg    <= res_v;
                skid_near_reg <= fin.near;
            end
        end
        else if (skid_valid_reg)
        begin
            out_dep_reg  <= skid_dep_reg;
            out_u_reg    <= skid_u_reg;
            out_v_reg    <= skid_v_reg;
            out_near_reg <= skid_near_reg;
        end
        else
        begin
            out_dep_reg  <= fin.dep;
            out_u_reg    <= res_u;
            out_v_reg    <= res_v;
            out_near_reg <= fin.near;
        end
    end

    assign out_valid  = out_valid_reg;
    assign depth      = out_dep_reg;
    assign pix_u      = out_u_reg;
    assign pix_v      = out_v_reg;
    assign near_plane = out_near_reg;

    // checks
`include "assert_macros.svh"
    `ASSERT_IMPL(a_near_blank, out_valid && near_plane, pix_u == 20'sd0 && pix_v == 20'sd0, "near item with nonzero pixels")
    `ASSERT_IMPL(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid holds an item while output is empty")
    `ASSERT_NEXT(a_skid_drains, !(out_valid_reg && out_stall), !skid_valid_reg, "skid not drained after output moved")

endmodule
